/* sv/svd_pkg.sv */
// Package for the stream vbyte decoder: decoder state, step result and register indexes.
// Shared by svd_step, stream_vbyte_decoder_top and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package svd_pkg;

    localparam logic [1:0] CFG_VALUE_COUNT = 2'd0;
    localparam logic [1:0] CFG_LENGTH_MODE = 2'd1;

    typedef struct packed {
        logic [7:0]  key_hold;
        logic [1:0]  lane;
        logic        expect_key;
        logic [1:0]  byte_pos;
        logic [31:0] accum;
        logic [31:0] values_left;
        logic [31:0] data_count;
    } dec_state_t;

    // One request's worth of results: value goes on the first one, zeros on the rest.
    typedef struct packed {
        logic [2:0]  count;
        logic [31:0] value;
        logic        last;
        logic        status;
        logic [31:0] bytes_used;
    } step_res_t;

    function automatic logic [2:0] code_len(input logic [1:0] code, input logic mode);
        logic [2:0] len;
        if (!mode) begin
            len = {1'b0, code} + 3'd1;
        end else if (code == 2'd3) begin
            len = 3'd4;
        end else begin
            len = {1'b0, code};
        end
        return len;
    endfunction

    function automatic dec_state_t restart_state(input logic [31:0] count);
        dec_state_t st;
        st             = '0;
        st.expect_key  = 1'b1;
        st.values_left = count;
        return st;
    endfunction

endpackage

`default_nettype wire

/* sv/svd_step.sv */
// Next-state and result logic for one input byte of the stream vbyte decoder.
// Purely combinational; uses svd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svd_step (
    input  svd_pkg::dec_state_t st,
    input  logic                length_mode,
    input  logic [7:0]          in_byte,
    input  logic                is_key,
    output svd_pkg::dec_state_t st_next,
    output svd_pkg::step_res_t  res
);
    import svd_pkg::*;

    logic        seq_err;
    logic        emit_first;
    logic        run_zeros;
    logic        running;
    logic [2:0]  start_lane;
    logic [2:0]  zcnt;
    logic [2:0]  end_lane;
    logic [31:0] vl;
    logic [31:0] vl_end;
    logic [31:0] acc;
    logic [31:0] first_val;
    logic [7:0]  key;
    logic [1:0]  cur_code;

    assign seq_err  = (st.values_left == 32'd0) || (is_key != st.expect_key);
    assign key      = is_key ? in_byte : st.key_hold;
    assign cur_code = st.key_hold[{st.lane, 1'b0} +: 2];
    assign acc      = st.accum | ({24'd0, in_byte} << {st.byte_pos, 3'b000});

    always_comb begin
        st_next        = st;
        res            = '0;
        res.bytes_used = st.data_count;
        emit_first     = 1'b0;
        run_zeros      = 1'b0;
        start_lane     = 3'd0;
        vl             = st.values_left;
        first_val      = 32'd0;
        zcnt           = 3'd0;
        running        = 1'b1;
        end_lane       = 3'd0;
        vl_end         = vl;

        if (seq_err) begin
            res.count  = 3'd1;
            res.status = 1'b1;
        end else if (is_key) begin
            st_next.key_hold   = in_byte;
            st_next.byte_pos   = 2'd0;
            st_next.accum      = 32'd0;
            st_next.expect_key = 1'b0;
            run_zeros          = 1'b1;
        end else begin
            st_next.data_count = st.data_count + 32'd1;
            res.bytes_used     = st.data_count + 32'd1;
            if ({1'b0, st.byte_pos} + 3'd1 >= code_len(cur_code, length_mode)) begin
                st_next.accum    = 32'd0;
                st_next.byte_pos = 2'd0;
                emit_first       = 1'b1;
                first_val        = acc;
                vl               = st.values_left - 32'd1;
                start_lane       = {1'b0, st.lane} + 3'd1;
                run_zeros        = 1'b1;
            end else begin
                st_next.accum    = acc;
                st_next.byte_pos = st.byte_pos + 2'd1;
            end
        end

        if (run_zeros) begin
            for (int i = 0; i < 4; i++) begin
                if (running && (3'(i) >= start_lane)) begin
                    if (length_mode && (key[2*i +: 2] == 2'd0) && (vl != {29'd0, zcnt})) begin
                        zcnt = zcnt + 3'd1;
                    end else begin
                        running = 1'b0;
                    end
                end
            end
            end_lane = start_lane + zcnt;
            vl_end   = vl - {29'd0, zcnt};
            if (end_lane[2] || (vl_end == 32'd0)) begin
                st_next.lane       = 2'd0;
                st_next.expect_key = 1'b1;
            end else begin
                st_next.lane       = end_lane[1:0];
                st_next.expect_key = 1'b0;
            end
            st_next.values_left = vl_end;
            res.count           = {2'd0, emit_first} + zcnt;
            res.value           = first_val;
            res.last            = (vl_end == 32'd0);
        end
    end

endmodule

`default_nettype wire

/* sv/stream_vbyte_decoder_top.sv */
// Top level of the stream vbyte decoder: config registers, decoder state and result drain.
// Instantiates svd_step; uses svd_pkg.
//
//  channel | direction | tdata / data                      | tuser / index | tlast
//  s_      | in        | [7:0] in_byte                     | [0] is_key    | -
//  m_      | out       | [31:0] value, [63:32] bytes_used  | [0] status    | last
//  cfg_    | in        | [31:0] register value             | [1:0] index   | -
//
// One input byte is taken per cycle while no result is pending; it yields zero to four results, drained one per cycle.
// A byte that yields several results holds the input until its last result is being taken (the result drain).
// Reset and a write to the value count or length mode register restart the block; no clearing pass is needed.
// Input ready follows output ready while the last queued result is waiting.
`timescale 1ns / 1ps
`default_nettype none

module stream_vbyte_decoder_top (
    input  wire  logic        aclk,
    input  wire  logic        aresetn,
    input  wire  logic        s_tvalid,
    output logic              s_tready,
    input  wire  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire  logic [0:0]  s_tuser,   // [0] is_key
    output logic              m_tvalid,
    input  wire  logic        m_tready,
    output logic [63:0]       m_tdata,   // [31:0] value, [63:32] bytes_used
    output logic [0:0]        m_tuser,   // [0] status
    output logic              m_tlast,
    input  wire  logic        cfg_valid,
    output logic              cfg_ready,
    input  wire  logic [1:0]  cfg_index,
    input  wire  logic [31:0] cfg_data
);
    import svd_pkg::*;

    dec_state_t  st_reg;
    dec_state_t  st_next;
    step_res_t   res;
    logic [31:0] value_count_reg;
    logic        length_mode_reg;
    logic [2:0]  left_reg;
    logic        first_reg;
    logic [31:0] value_reg;
    logic        last_reg;
    logic        status_reg;
    logic [31:0] bytes_reg;
    logic        s_fire;
    logic        m_fire;
    logic        cfg_fire;

    svd_step u_step (
        .st          (st_reg),
        .length_mode (length_mode_reg),
        .in_byte     (s_tdata),
        .is_key      (s_tuser[0]),
        .st_next     (st_next),
        .res         (res)
    );

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_tready  = (left_reg == 3'd0) || ((left_reg == 3'd1) && m_tready);
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = (left_reg != 3'd0);
    assign m_fire    = m_tvalid && m_tready;
    assign m_tdata   = {bytes_reg, (first_reg ? value_reg : 32'd0)};
    assign m_tuser   = status_reg;
    assign m_tlast   = last_reg && (left_reg == 3'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_count_reg <= 32'd0;
            length_mode_reg <= 1'b0;
            st_reg          <= restart_state(32'd0);
            left_reg        <= 3'd0;
            first_reg       <= 1'b0;
        end else begin
            if (cfg_fire) begin
                unique case (cfg_index)
                    CFG_VALUE_COUNT: begin
                        value_count_reg <= cfg_data;
                        st_reg          <= restart_state(cfg_data);
                    end
                    CFG_LENGTH_MODE: begin
                        length_mode_reg <= cfg_data[0];
                        st_reg          <= restart_state(value_count_reg);
                    end
                    default: begin
                    end
                endcase
            end else if (s_fire) begin
                st_reg <= st_next;
            end

            if (s_fire) begin
                left_reg  <= res.count;
                first_reg <= 1'b1;
            end else if (m_fire) begin
                left_reg  <= left_reg - 3'd1;
                first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            value_reg  <= res.value;
            last_reg   <= res.last;
            status_reg <= res.status;
            bytes_reg  <= res.bytes_used;
        end
    end

endmodule

`default_nettype wire

/* sv/svd_checker.sv */
// Port-level checks for stream_vbyte_decoder_top, bound onto every instance of it.
// Sees only the top level's ports; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module svd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'd0)
        else $error("error result carries a nonzero value");

    a_err_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tlast)
        else $error("error result marked last");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !(s_tvalid && s_tready))
        else $error("input taken over a stalled result");

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no pending result");

endmodule

bind stream_vbyte_decoder_top svd_checker u_svd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* verif/stream_vbyte_decoder_top_tb.sv */
`timescale 1ns / 1ps
// Testbench for stream_vbyte_decoder_top: a directed table, then random key/data byte streams.
// Every result is checked against an in-bench decoder model or a pinned expected value; depends on svd_pkg and the DUT.

module stream_vbyte_decoder_top_tb;
    import svd_pkg::*;

    localparam real  CLK_PERIOD     = 12.0;
    localparam int   DRAIN_CYCLES   = 16;
    localparam int   TIMEOUT_CYCLES = 400000;
    localparam int   RANDOM_ITEMS   = 445;
    localparam int   HOLD_CYCLES    = 120;
    localparam logic KIND_KEY       = 1'b1;
    localparam logic KIND_DATA      = 1'b0;
    localparam logic ST_OK          = 1'b0;
    localparam logic ST_SEQ_ERR     = 1'b1;
    localparam logic MODE_STD       = 1'b0;
    localparam logic MODE_ALT       = 1'b1;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        status;
        logic [31:0] bytes_used;
    } dec_result_t;

    typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [1:0]  reg_idx;
        logic [31:0] word;
        logic        is_key;
        logic        pinned;
        dec_result_t want;
    } stim_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // decoder model state
    logic [31:0] cfg_count = '0;
    logic        cfg_mode  = MODE_STD;
    logic [7:0]  pd_key;
    logic [2:0]  pd_lane;
    logic        pd_wait_key;
    logic [1:0]  pd_pos;
    logic [31:0] pd_accum;
    logic [31:0] pd_left;
    logic [31:0] pd_used;

    dec_result_t due_values[$];
    stim_row_t   dir_rows[$];
    int          mismatch_count = 0;
    int          burst_left     = 0;
    int          hold_req       = 0;

    stream_vbyte_decoder_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic logic [2:0] lane_bytes(input logic [1:0] code);
        case (code)
            2'd0: return (cfg_mode == MODE_ALT) ? 3'd0 : 3'd1;
            2'd1: return (cfg_mode == MODE_ALT) ? 3'd1 : 3'd2;
            2'd2: return (cfg_mode == MODE_ALT) ? 3'd2 : 3'd3;
            default: return 3'd4;
        endcase
    endfunction

    function automatic logic [1:0] lane_code();
        return 2'(pd_key >> (pd_lane[1:0] * 2));
    endfunction

    task automatic restart_block();
        pd_key      = '0;
        pd_lane     = '0;
        pd_wait_key = 1'b1;
        pd_pos      = '0;
        pd_accum    = '0;
        pd_left     = cfg_count;
        pd_used     = '0;
    endtask

    task automatic push_value(input logic [31:0] v);
        pd_left--;
        due_values.push_back('{v, pd_left == 0, ST_OK, pd_used});
    endtask

    // emit zeros for zero-length lanes, then go back to waiting for a key when the key is spent or no values are left
    task automatic flush_zero_lanes();
        while (pd_left != 0 && pd_lane < 4 && lane_bytes(lane_code()) == 3'd0) begin
            push_value('0);
            pd_lane++;
        end
        if (pd_lane >= 4 || pd_left == 0) begin
            pd_lane     = '0;
            pd_wait_key = 1'b1;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic k);
        if (pd_left == 0 || k != pd_wait_key) begin
            due_values.push_back('{32'd0, 1'b0, ST_SEQ_ERR, pd_used});
            return;
        end
        if (k == KIND_KEY) begin
            pd_key      = b;
            pd_lane     = '0;
            pd_pos      = '0;
            pd_accum    = '0;
            pd_wait_key = 1'b0;
            flush_zero_lanes();
            return;
        end
        pd_accum = pd_accum | (32'(b) << (pd_pos * 8));
        pd_used++;
        if (int'(pd_pos) + 1 >= int'(lane_bytes(lane_code()))) begin
            push_value(pd_accum);
            pd_accum = '0;
            pd_pos   = '0;
            pd_lane++;
            flush_zero_lanes();
        end else begin
            pd_pos++;
        end
    endtask

    function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [31:0] d);
        stim_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.word    = d;
        return r;
    endfunction

    function automatic stim_row_t byte_row(input logic [7:0] b, input logic k);
        stim_row_t r;
        r        = '0;
        r.kind   = ROW_BYTE;
        r.word   = {24'd0, b};
        r.is_key = k;
        return r;
    endfunction

    function automatic stim_row_t pinned_row(input logic [7:0] b, input logic k,
                                             input logic [31:0] v, input logic last,
                                             input logic st, input logic [31:0] used);
        stim_row_t r;
        r        = byte_row(b, k);
        r.pinned = 1'b1;
        r.want   = '{v, last, st, used};
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic k, input logic pinned,
                             input dec_result_t want);
        int gap;
        int n0;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 16);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= k;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        n0 = due_values.size();
        decode_byte(b, k);
        if (pinned) begin
            while (due_values.size() > n0) void'(due_values.pop_back());
            due_values.push_back(want);
        end
    endtask

    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (due_values.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_VALUE_COUNT) begin
            cfg_count = d;
        end else if (idx == CFG_LENGTH_MODE) begin
            cfg_mode = d[0];
        end
        restart_block();
    endtask

    // receiver pacing: random styles, plus long hold-offs on request
    always @(posedge aclk) begin : rx_pacing
        logic        ready;
        logic [31:0] rx_tick;
        int          rx_style;
        int          rx_left;
        int          hold_left;
        int          hold_done;
        if (rx_tick === 'x) begin
            rx_tick   = '0;
            rx_left   = 0;
            hold_left = 0;
            hold_done = 0;
        end
        rx_tick++;
        if (hold_done != hold_req) begin
            hold_done++;
            hold_left = HOLD_CYCLES;
        end
        if (rx_left == 0) begin
            rx_style = $urandom_range(0, 3);
            rx_left  = $urandom_range(20, 150);
        end
        rx_left--;
        case (rx_style)
            0: ready = 1'b1;
            1: ready = 1'($urandom_range(0, 1));
            2: ready = (rx_tick[2:0] != 3'd5) && !(rx_tick[3] && rx_tick[0]);
            default: ready = ($urandom_range(0, 3) == 0);
        endcase
        if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
        end
        m_tready <= ready;
    end

    always @(posedge aclk) begin : result_check
        dec_result_t got;
        dec_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[31:0], m_tlast, m_tuser[0], m_tdata[63:32]};
            if (due_values.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: value %h last %b status %b bytes_used %0d",
                             got.value, got.last, got.status, got.bytes_used);
                end
            end else begin
                want = due_values.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected value %h last %b status %b used %0d",
                                 want.value, want.last, want.status, want.bytes_used);
                        $display("          got      value %h last %b status %b used %0d",
                                 got.value, got.last, got.status, got.bytes_used);
                    end
                end
            end
        end
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int          blk;
        int          sent;
        int          cap;
        logic        k;
        logic [7:0]  b;
        logic [31:0] count;
        logic        mode;
        dir_rows = '{
            pinned_row(8'h00, KIND_DATA, 32'd0, 1'b0, ST_SEQ_ERR, 32'd0),
            cfg_row(CFG_VALUE_COUNT, 32'd5),
            cfg_row(CFG_LENGTH_MODE, {31'd0, MODE_STD}),
            byte_row(8'hE4, KIND_KEY),
            pinned_row(8'hA5, KIND_KEY, 32'd0, 1'b0, ST_SEQ_ERR, 32'd0),
            pinned_row(8'hFF, KIND_DATA, 32'h0000_00FF, 1'b0, ST_OK, 32'd1),
            byte_row(8'h01, KIND_DATA),
            byte_row(8'h02, KIND_DATA),
            byte_row(8'h00, KIND_DATA),
            byte_row(8'h80, KIND_DATA),
            byte_row(8'h7F, KIND_DATA),
            byte_row(8'hFF, KIND_DATA),
            byte_row(8'hFF, KIND_DATA),
            byte_row(8'hFF, KIND_DATA),
            pinned_row(8'hFF, KIND_DATA, 32'hFFFF_FFFF, 1'b0, ST_OK, 32'd10),
            pinned_row(8'h3C, KIND_DATA, 32'd0, 1'b0, ST_SEQ_ERR, 32'd10),
            byte_row(8'h00, KIND_KEY),
            pinned_row(8'h7F, KIND_DATA, 32'h0000_007F, 1'b1, ST_OK, 32'd11),
            pinned_row(8'hFF, KIND_KEY, 32'd0, 1'b0, ST_SEQ_ERR, 32'd11),
            cfg_row(CFG_LENGTH_MODE, {31'd0, MODE_ALT}),
            cfg_row(CFG_VALUE_COUNT, 32'd6),
            byte_row(8'h00, KIND_KEY),
            byte_row(8'hD0, KIND_KEY),
            cfg_row(CFG_VALUE_COUNT, 32'd4),
            byte_row(8'h07, KIND_KEY),
            byte_row(8'h11, KIND_DATA),
            byte_row(8'h22, KIND_DATA),
            byte_row(8'h33, KIND_DATA),
            byte_row(8'h44, KIND_DATA),
            byte_row(8'h55, KIND_DATA)
        };
        restart_block();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_reg(dir_rows[i].reg_idx, dir_rows[i].word);
            end else begin
                send_byte(dir_rows[i].word[7:0], dir_rows[i].is_key, dir_rows[i].pinned,
                          dir_rows[i].want);
            end
        end

        blk  = 0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: count = 32'd0;
                1: count = 32'hFFFF_FFFF;
                2: count = $urandom();
                default: count = $urandom_range(1, 12);
            endcase
            if (blk == 1 || blk == 6) begin
                count = $urandom_range(40, 60);
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_VALUE_COUNT, count);
            end else if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_LENGTH_MODE, {31'd0, mode});
                write_reg(CFG_VALUE_COUNT, count);
            end else begin
                write_reg(CFG_VALUE_COUNT, count);
                write_reg(CFG_LENGTH_MODE, {31'd0, mode});
            end
            cap = $urandom_range(12, 60);
            if (blk == 1 || blk == 6) begin
                hold_req++;
                cap = 60;
            end
            for (int n = 0; n < cap && sent < RANDOM_ITEMS; n++) begin
                if (pd_left == 0) begin
                    if ($urandom_range(0, 1) == 1) begin
                        send_byte(8'($urandom()), 1'($urandom()), 1'b0, '0);
                        sent++;
                    end
                    break;
                end
                k = ($urandom_range(0, 15) == 0) ? ~pd_wait_key : pd_wait_key;
                b = 8'($urandom_range(0, 255));
                // thin out key codes so zero-length lanes show up often
                if (k == KIND_KEY && $urandom_range(0, 3) == 0) begin
                    b = b & 8'($urandom());
                end
                send_byte(b, k, 1'b0, '0);
                sent++;
            end
            blk++;
        end

        wait_idle();
        if (mismatch_count == 0 && due_values.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
